// ===== design/dtdf_pkg.sv =====
// Shared constants and types for the dual timer digit formatter.
`timescale 1ns / 1ps
`default_nettype none
package dtdf_pkg;

  localparam int unsigned TIME_W      = 26;
  localparam int unsigned IN_DATA_W   = 56;
  localparam int unsigned OUT_DATA_W  = 64;
  localparam int unsigned CHAR_W      = 7;
  localparam int unsigned STAGES      = 9;

  localparam logic [TIME_W-1:0] TIME_MAX_MS = 26'd35999999;

  // Floor reciprocals; the quotient estimate is exact or one low.
  localparam logic [16:0] RECIP_1000 = 17'd67108;   // 2^26 / 1000
  localparam logic [10:0] RECIP_60_S = 11'd1092;    // 2^16 / 60
  localparam logic [4:0]  RECIP_60_M = 5'd17;       // 2^10 / 60

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'd48;
  localparam logic [CHAR_W-1:0] ASCII_HOUR = 7'd104;

  typedef struct packed {
    logic [3:0] hours;
    logic [2:0] min_tens;
    logic [3:0] min_units;
    logic [2:0] sec_tens;
    logic [3:0] sec_units;
    logic [3:0] tenths;
    logic [3:0] hundredths;
  } dtdf_digits_t;

endpackage
`default_nettype wire

// ===== design/dtdf_pipe_ctrl.sv =====
// Valid and ready chain for the formatter pipeline stages.
`timescale 1ns / 1ps
`default_nettype none
module dtdf_pipe_ctrl
  import dtdf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              up_valid,
  output logic                   up_ready,
  output logic                   dn_valid,
  input  wire logic              dn_ready,
  output logic [STAGES-1:0]      stage_en
);

  logic [STAGES-1:0] valid_r;
  logic [STAGES-1:0] valid_nxt;
  logic [STAGES:0]   ready;
  logic [STAGES-1:0] valid_in;

  always_comb begin
    ready[STAGES] = dn_ready;
    for (int i = STAGES - 1; i >= 0; i--) begin
      ready[i] = !valid_r[i] || ready[i+1];
    end
  end

  // Stage i takes the upstream valid whenever it can move.
  always_comb begin
    valid_in[0] = up_valid;
    for (int i = 1; i < STAGES; i++) begin
      valid_in[i] = valid_r[i-1];
    end
    for (int i = 0; i < STAGES; i++) begin
      valid_nxt[i] = ready[i] ? valid_in[i] : valid_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign stage_en = ready[STAGES-1:0];
  assign up_ready = ready[0];
  assign dn_valid = valid_r[STAGES-1];

endmodule
`default_nettype wire

// ===== design/dtdf_timer_conv.sv =====
// Pipelined split of one millisecond count into display digits.
`timescale 1ns / 1ps
`default_nettype none
module dtdf_timer_conv
  import dtdf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic [7:0]        stage_en,
  input  wire logic [TIME_W-1:0] time_ms,
  output dtdf_digits_t           digits
);

  // Stage A: saturate
  logic [TIME_W-1:0] t_a_r;
  logic [TIME_W-1:0] t_a_nxt;
  assign t_a_nxt = (time_ms > TIME_MAX_MS) ? TIME_MAX_MS : time_ms;

  // Stage B: estimate whole seconds
  logic [42:0]       prod_b;
  logic [15:0]       q_b_r;
  logic [15:0]       q_b_nxt;
  logic [TIME_W-1:0] t_b_r;
  assign prod_b  = 43'(t_a_r) * 43'(RECIP_1000);
  assign q_b_nxt = prod_b[41:26];

  // Stage C: correct seconds, keep milliseconds
  logic [TIME_W-1:0] qk_c;
  logic [TIME_W-1:0] rem_c;
  logic [10:0]       r_c;
  logic [15:0]       s_c_r;
  logic [15:0]       s_c_nxt;
  logic [9:0]        ms_c_r;
  logic [9:0]        ms_c_nxt;
  assign qk_c  = 26'(q_b_r) * 26'd1000;
  assign rem_c = t_b_r - qk_c;
  assign r_c   = rem_c[10:0];
  always_comb begin
    if (r_c >= 11'd1000) begin
      s_c_nxt  = q_b_r + 16'd1;
      ms_c_nxt = 10'(r_c - 11'd1000);
    end else begin
      s_c_nxt  = q_b_r;
      ms_c_nxt = r_c[9:0];
    end
  end

  // Stage D: estimate total minutes, take tenths and centiseconds
  logic [26:0] prod_d;
  logic [15:0] prod_tn;
  logic [17:0] prod_cs;
  logic [9:0]  m_d_r;
  logic [15:0] s_d_r;
  logic [3:0]  tn_d_r;
  logic [6:0]  cs_d_r;
  assign prod_d  = 27'(s_c_r) * 27'(RECIP_60_S);
  assign prod_tn = 16'(ms_c_r) * 16'd41;
  assign prod_cs = 18'(ms_c_r) * 18'd205;

  // Stage E: correct total minutes, hundredths
  logic [15:0] rem_e;
  logic [6:0]  r_e;
  logic [9:0]  tm_e_r;
  logic [9:0]  tm_e_nxt;
  logic [5:0]  sec_e_r;
  logic [5:0]  sec_e_nxt;
  logic [3:0]  tn_e_r;
  logic [3:0]  hu_e_r;
  logic [3:0]  hu_e_nxt;
  assign rem_e = s_d_r - 16'(m_d_r) * 16'd60;
  assign r_e   = rem_e[6:0];
  assign hu_e_nxt = 4'(cs_d_r - 7'(tn_d_r) * 7'd10);
  always_comb begin
    if (r_e >= 7'd60) begin
      tm_e_nxt  = m_d_r + 10'd1;
      sec_e_nxt = 6'(r_e - 7'd60);
    end else begin
      tm_e_nxt  = m_d_r;
      sec_e_nxt = r_e[5:0];
    end
  end

  // Stage F: estimate hours, seconds tens
  logic [14:0] prod_f;
  logic [9:0]  prod_st;
  logic [3:0]  h_f_r;
  logic [9:0]  tm_f_r;
  logic [5:0]  sec_f_r;
  logic [2:0]  st_f_r;
  logic [3:0]  tn_f_r;
  logic [3:0]  hu_f_r;
  assign prod_f  = 15'(tm_e_r) * 15'(RECIP_60_M);
  assign prod_st = 10'(sec_e_r) * 10'd13;

  // Stage G: correct hours, seconds units
  logic [9:0] rem_g;
  logic [6:0] r_g;
  logic [3:0] h_g_r;
  logic [3:0] h_g_nxt;
  logic [5:0] min_g_r;
  logic [5:0] min_g_nxt;
  logic [2:0] st_g_r;
  logic [3:0] su_g_r;
  logic [3:0] tn_g_r;
  logic [3:0] hu_g_r;
  assign rem_g = tm_f_r - 10'(h_f_r) * 10'd60;
  assign r_g   = rem_g[6:0];
  always_comb begin
    if (r_g >= 7'd60) begin
      h_g_nxt   = h_f_r + 4'd1;
      min_g_nxt = 6'(r_g - 7'd60);
    end else begin
      h_g_nxt   = h_f_r;
      min_g_nxt = r_g[5:0];
    end
  end

  // Stage H: minute digits
  logic [9:0]   prod_mt;
  logic [2:0]   mt_h;
  dtdf_digits_t digits_r;
  dtdf_digits_t digits_nxt;
  assign prod_mt = 10'(min_g_r) * 10'd13;
  assign mt_h    = prod_mt[9:7];
  always_comb begin
    digits_nxt.hours      = h_g_r;
    digits_nxt.min_tens   = mt_h;
    digits_nxt.min_units  = 4'(min_g_r - 6'(mt_h) * 6'd10);
    digits_nxt.sec_tens   = st_g_r;
    digits_nxt.sec_units  = su_g_r;
    digits_nxt.tenths     = tn_g_r;
    digits_nxt.hundredths = hu_g_r;
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      t_a_r <= t_a_nxt;
    end
    if (stage_en[1]) begin
      q_b_r <= q_b_nxt;
      t_b_r <= t_a_r;
    end
    if (stage_en[2]) begin
      s_c_r  <= s_c_nxt;
      ms_c_r <= ms_c_nxt;
    end
    if (stage_en[3]) begin
      m_d_r  <= prod_d[25:16];
      s_d_r  <= s_c_r;
      tn_d_r <= prod_tn[15:12];
      cs_d_r <= prod_cs[17:11];
    end
    if (stage_en[4]) begin
      tm_e_r  <= tm_e_nxt;
      sec_e_r <= sec_e_nxt;
      tn_e_r  <= tn_d_r;
      hu_e_r  <= hu_e_nxt;
    end
    if (stage_en[5]) begin
      h_f_r   <= prod_f[13:10];
      tm_f_r  <= tm_e_r;
      sec_f_r <= sec_e_r;
      st_f_r  <= prod_st[9:7];
      tn_f_r  <= tn_e_r;
      hu_f_r  <= hu_e_r;
    end
    if (stage_en[6]) begin
      h_g_r   <= h_g_nxt;
      min_g_r <= min_g_nxt;
      st_g_r  <= st_f_r;
      su_g_r  <= 4'(sec_f_r - 6'(st_f_r) * 6'd10);
      tn_g_r  <= tn_f_r;
      hu_g_r  <= hu_f_r;
    end
    if (stage_en[7]) begin
      digits_r <= digits_nxt;
    end
  end

  assign digits = digits_r;

endmodule
`default_nettype wire

// ===== design/dual_timer_digit_formatter.sv =====
// Top level: two millisecond timers to eight ASCII display characters and dots.
`timescale 1ns / 1ps
`default_nettype none
// Converts a pair of remaining times in milliseconds into eight ASCII codes
// and a decimal-point mask for an eight-digit display; positions 0-3 show the
// right timer, 4-7 the left one. Each timer shows "Hhmm" when hours are above
// zero, "MM.SS" when minutes are, and "SS.tc" (tenths, hundredths) otherwise.
// Inputs above 35999999 ms hold at that value. The block takes one request
// per clock while no stall holds in_tready low; its pipeline holds the
// saturation stage, the three reciprocal divisions (by 1000, 60 and 60), each
// split into an estimate stage and a correction stage, plus the digit and
// character stages. A full output register with out_tready low stalls the
// pipeline stage by stage, so empty stages still fill while the result waits.
module dual_timer_digit_formatter
  import dtdf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // left_time_ms, right_time_ms, zero pad
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata   // char_0 .. char_7, dot_mask
);

  logic [STAGES-1:0] stage_en;
  dtdf_digits_t      left_dig;
  dtdf_digits_t      right_dig;

  dtdf_pipe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .stage_en (stage_en)
  );

  dtdf_timer_conv u_conv_left (
    .clk      (clk),
    .stage_en (stage_en[7:0]),
    .time_ms  (in_tdata[TIME_W-1:0]),
    .digits   (left_dig)
  );

  dtdf_timer_conv u_conv_right (
    .clk      (clk),
    .stage_en (stage_en[7:0]),
    .time_ms  (in_tdata[2*TIME_W-1:TIME_W]),
    .digits   (right_dig)
  );

  // Pick the display mode of one timer and build its four characters.
  function automatic logic [4*CHAR_W:0] fmt_timer(input dtdf_digits_t d);
    logic [CHAR_W-1:0] c0;
    logic [CHAR_W-1:0] c1;
    logic [CHAR_W-1:0] c2;
    logic [CHAR_W-1:0] c3;
    logic              dot;
    if (d.hours != 4'd0) begin
      c0  = ASCII_ZERO + 7'(d.hours);
      c1  = ASCII_HOUR;
      c2  = ASCII_ZERO + 7'(d.min_tens);
      c3  = ASCII_ZERO + 7'(d.min_units);
      dot = 1'b0;
    end else if (d.min_tens != 3'd0 || d.min_units != 4'd0) begin
      c0  = ASCII_ZERO + 7'(d.min_tens);
      c1  = ASCII_ZERO + 7'(d.min_units);
      c2  = ASCII_ZERO + 7'(d.sec_tens);
      c3  = ASCII_ZERO + 7'(d.sec_units);
      dot = 1'b1;
    end else begin
      c0  = ASCII_ZERO + 7'(d.sec_tens);
      c1  = ASCII_ZERO + 7'(d.sec_units);
      c2  = ASCII_ZERO + 7'(d.tenths);
      c3  = ASCII_ZERO + 7'(d.hundredths);
      dot = 1'b1;
    end
    return {dot, c3, c2, c1, c0};
  endfunction

  logic [4*CHAR_W:0]     right_fmt;
  logic [4*CHAR_W:0]     left_fmt;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_DATA_W-1:0] out_data_nxt;

  assign right_fmt = fmt_timer(right_dig);
  assign left_fmt  = fmt_timer(left_dig);

  // Dots sit on each timer's second character: bit 1 right, bit 5 left.
  always_comb begin
    out_data_nxt = {2'b00, left_fmt[4*CHAR_W], 3'b000, right_fmt[4*CHAR_W], 1'b0,
                    left_fmt[4*CHAR_W-1:0], right_fmt[4*CHAR_W-1:0]};
  end

  // Output register: the last pipeline stage; load only when it may advance.
  always_ff @(posedge clk) begin
    if (stage_en[STAGES-1]) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tdata = out_data_r;

  // Only the two second-character dots can ever light.
  a_dot_bits : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[63:56] & 8'hDD) == 8'h00)
    else $error("dot outside the second character");

  // The hour marker never shows together with a dot on the right timer.
  a_hour_nodot : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[13:7] == ASCII_HOUR |-> !out_tdata[57])
    else $error("hour mode with dot lit");

  // First character of each timer is always a decimal digit.
  a_first_digit : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[6:0] >= ASCII_ZERO && out_tdata[6:0] <= 7'd57
                && out_tdata[34:28] >= ASCII_ZERO && out_tdata[34:28] <= 7'd57)
    else $error("first character not a digit");

  // An empty output stage means the whole pipeline can take a request.
  a_empty_ready : assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

endmodule
`default_nettype wire
